FILE: src/sbb_pkg.sv
// sbb_pkg: payload structs, configuration codes and the fixed blend table
// for the sprite blitter; no dependencies
package sbb_pkg;

  localparam int unsigned DimW    = 11;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned PixW    = 10;
  localparam int unsigned NumPix  = 64;
  localparam int unsigned IdxW    = 6;
  localparam logic [DimW-1:0] MaxDim = 11'd1024;

  typedef enum logic [0:0] {
    CfgScreenWidth  = 1'b0,
    CfgScreenHeight = 1'b1
  } sbb_cfg_e;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [63:0] plane_low;
    logic [63:0] plane_high;
    logic [3:0]  color_mode;
    logic        flip_x;
    logic        flip_y;
    logic        two_bpp;
    logic        layer_sel;
  } sbb_in_t;

  typedef struct packed {
    logic [9:0] pix_x;
    logic [9:0] pix_y;
    logic [1:0] pix_value;
    logic       pix_layer;
    logic       last;
  } sbb_out_t;

  // one sprite after clipping: surviving pixels and their blended values
  typedef struct packed {
    logic [NumPix-1:0]      mask;
    logic [NumPix-1:0][1:0] vals;
    logic [15:0]            pos_x;
    logic [15:0]            pos_y;
    logic                   flip_x;
    logic                   flip_y;
    logic                   layer;
  } sbb_job_t;

  function automatic logic [1:0] blend(input logic [1:0] ch, input logic [3:0] mode);
    logic [15:0][1:0] row;
    begin
      unique case (ch)
        2'd0: row = {2'd0, 2'd3, 2'd3, 2'd3, 2'd2, 2'd0, 2'd2, 2'd2,
                     2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0};
        2'd1: row = {2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0,
                     2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0};
        2'd2: row = {2'd1, 2'd3, 2'd2, 2'd1, 2'd1, 2'd3, 2'd2, 2'd1,
                     2'd1, 2'd3, 2'd2, 2'd1, 2'd1, 2'd3, 2'd2, 2'd1};
        default: row = {2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd1, 2'd3, 2'd2,
                        2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd1, 2'd3, 2'd2};
      endcase
      return row[mode];
    end
  endfunction

  // modes that are multiples of five make value zero transparent
  function automatic logic is_opaque(input logic [3:0] mode);
    return (mode != 4'd0) && (mode != 4'd5) && (mode != 4'd10) && (mode != 4'd15);
  endfunction

endpackage

FILE: src/sprite_blit_blend_top.sv
// sprite_blit_blend_top: 8x8 sprite blitter with blending, top level
// depends on sbb_pkg, sbb_mask and sbb_scan
//
// usage:
//   a sprite command is a transfer on the input channel (in_valid_i, in_stall_o,
//   in_data_i); each surviving pixel leaves as one transfer on the output
//   channel (out_valid_o, out_stall_i, out_data_o), row by row, left to right
//   before flipping, with last set on the final write of the sprite
//   a sprite that leaves no pixel on screen produces no transfer
//   a sprite passes the input register, the scan register and the output register
//   throughput: one write per cycle while the receiver does not stall; a sprite
//   occupies the scan register until its last surviving pixel (1 to 64) is sent;
//   the input register takes the next sprite while the current one is being sent
//   the user must write screen_width and screen_height through cfg_we_i only
//   while idle, which the block does not enforce; values above 1024 act as 1024
//   reset clears both registers to 400 by 240 and drops all pending work
//   when the receiver stalls, the output register holds its write, the scan
//   stops and, once the input register is full, in_stall_o rises
module sprite_blit_blend_top import sbb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [DimW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sbb_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sbb_out_t        out_data_o
);

  logic [DimW-1:0] width_q, height_q;
  logic            in_valid_q, in_valid_d;
  sbb_in_t         in_q;
  sbb_job_t        job;
  logic            scan_ready;
  logic            take;
  logic            in_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd400;
      height_q <= 11'd240;
    end else if (cfg_we_i) begin
      unique case (sbb_cfg_e'(cfg_idx_i))
        CfgScreenWidth:  width_q  <= cfg_data_i;
        CfgScreenHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign take       = in_valid_q && scan_ready;
  assign in_stall_o = in_valid_q && !scan_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (take) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
  end

  sbb_mask u_mask (
    .sprite_i (in_q),
    .width_i  (width_q),
    .height_i (height_q),
    .job_o    (job)
  );

  sbb_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .job_i       (job),
    .ready_o     (scan_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: src/sbb_mask.sv
// sbb_mask: clips one sprite against the screen and blends all 64 pixels
// depends on sbb_pkg
module sbb_mask import sbb_pkg::*; (
  input  sbb_in_t         sprite_i,
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  output sbb_job_t        job_o
);

  logic [DimW-1:0]   w_lim;
  logic [DimW-1:0]   h_lim;
  logic [7:0]        row_ok;
  logic [7:0]        col_ok;
  logic [63:0]       hi_plane;
  logic              opaque;

  assign w_lim    = (width_i > MaxDim) ? MaxDim : width_i;
  assign h_lim    = (height_i > MaxDim) ? MaxDim : height_i;
  assign hi_plane = sprite_i.two_bpp ? sprite_i.plane_high : 64'd0;
  assign opaque   = is_opaque(sprite_i.color_mode);

  always_comb begin
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
    for (int k = 0; k < 8; k++) begin
      y = sprite_i.pos_y + {13'd0, 3'(k) ^ {3{sprite_i.flip_y}}};
      x = sprite_i.pos_x + {13'd0, 3'(k) ^ {3{sprite_i.flip_x}}};
      row_ok[k] = {5'd0, h_lim} > y;
      col_ok[k] = {5'd0, w_lim} > x;
    end
  end

  always_comb begin
    logic [1:0] ch;
    job_o.pos_x  = sprite_i.pos_x;
    job_o.pos_y  = sprite_i.pos_y;
    job_o.flip_x = sprite_i.flip_x;
    job_o.flip_y = sprite_i.flip_y;
    job_o.layer  = sprite_i.layer_sel;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        ch = {hi_plane[63 - 8*r - c], sprite_i.plane_low[63 - 8*r - c]};
        job_o.mask[8*r + c] = row_ok[r] & col_ok[c] & (opaque | (ch != 2'd0));
        job_o.vals[8*r + c] = blend(ch, sprite_i.color_mode);
      end
    end
  end

endmodule

FILE: src/sbb_scan.sv
// sbb_scan: holds one clipped sprite and sends its pixel writes in order,
// one per cycle unless the receiver stalls, through an output register; depends on sbb_pkg
module sbb_scan import sbb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  sbb_job_t job_i,
  output logic     ready_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sbb_out_t out_data_o
);

  logic [NumPix-1:0]      mask_q, mask_d;
  logic [NumPix-1:0][1:0] vals_q;
  logic [15:0]            px_q, py_q;
  logic                   fx_q, fy_q, layer_q;
  logic                   out_valid_q, out_valid_d;
  sbb_out_t               out_q;
  logic [NumPix-1:0]      rest;
  logic [IdxW-1:0]        idx;
  logic                   emit;
  logic                   is_last;
  logic [CoordW-1:0]      x, y;

  always_comb begin
    idx = '0;
    for (int i = NumPix - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        idx = IdxW'(i);
      end
    end
  end

  assign rest    = mask_q & (mask_q - 64'd1);
  assign is_last = (rest == '0);
  assign emit    = (mask_q != '0) && (!out_valid_q || !out_stall_i);
  assign ready_o = (mask_q == '0) || (emit && is_last);
  assign x = px_q + {13'd0, idx[2:0] ^ {3{fx_q}}};
  assign y = py_q + {13'd0, idx[5:3] ^ {3{fy_q}}};

  always_comb begin
    mask_d = mask_q;
    if (emit) begin
      mask_d = rest;
    end
    if (load_i) begin
      mask_d = job_i.mask;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      vals_q  <= job_i.vals;
      px_q    <= job_i.pos_x;
      py_q    <= job_i.pos_y;
      fx_q    <= job_i.flip_x;
      fy_q    <= job_i.flip_y;
      layer_q <= job_i.layer;
    end
    if (emit) begin
      out_q.pix_x     <= x[PixW-1:0];
      out_q.pix_y     <= y[PixW-1:0];
      out_q.pix_value <= vals_q[idx];
      out_q.pix_layer <= layer_q;
      out_q.last      <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: verif/sbb_write_checker.sv
`timescale 1ns / 1ps
// sbb_write_checker: predicts the pixel writes of the sprite blitter from accepted
// sprites and the tracked screen size, and compares them with the output transfers
// depends on sbb_pkg
module sbb_write_checker import sbb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [DimW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  sbb_in_t         in_data_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  sbb_out_t        out_data_i,
  output int              writes_due_o,
  output int              fail_cnt_o
);

  // blend lookup, 32 bits per pixel value, 2 bits per color mode
  localparam logic [127:0] BlendLut = {32'h9E9E_9E9E, 32'h7979_7979,
                                       32'hE4E4_E4E4, 32'h3F8A_5100};

  logic [DimW-1:0] scr_w;
  logic [DimW-1:0] scr_h;
  sbb_out_t        writes_due[$];
  int              fails = 0;

  function automatic void predict_writes(input sbb_in_t spr);
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    logic [15:0]     x;
    logic [15:0]     y;
    logic [7:0]      lo_row;
    logic [7:0]      hi_row;
    logic [1:0]      pv;
    logic            see_through;
    logic            have_held;
    sbb_out_t        held;
    w = (scr_w > MaxDim) ? MaxDim : scr_w;
    h = (scr_h > MaxDim) ? MaxDim : scr_h;
    see_through = (int'(spr.color_mode) % 5) == 0;
    have_held = 1'b0;
    held = '0;
    for (int r = 0; r < 8; r++) begin
      y = spr.pos_y + 16'(3'(r) ^ {3{spr.flip_y}});
      if (y >= 16'(h)) continue;
      lo_row = spr.plane_low[63 - 8*r -: 8];
      hi_row = spr.two_bpp ? spr.plane_high[63 - 8*r -: 8] : 8'h00;
      for (int c = 0; c < 8; c++) begin
        x = spr.pos_x + 16'(3'(c) ^ {3{spr.flip_x}});
        pv = {hi_row[7 - c], lo_row[7 - c]};
        if (x >= 16'(w) || (see_through && pv == 2'd0)) continue;
        if (have_held) writes_due.push_back(held);
        held.pix_x     = x[9:0];
        held.pix_y     = y[9:0];
        held.pix_value = BlendLut[32*int'(pv) + 2*int'(spr.color_mode) +: 2];
        held.pix_layer = spr.layer_sel;
        held.last      = 1'b0;
        have_held      = 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      writes_due.push_back(held);
    end
  endfunction

  function automatic int field_bad(input string name, input logic [9:0] want,
                                   input logic [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    sbb_out_t want;
    if (!rst_ni) begin
      scr_w <= 11'd400;
      scr_h <= 11'd240;
      writes_due.delete();
      writes_due_o <= 0;
      fail_cnt_o   <= fails;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (writes_due.size() == 0) begin
          $error("unexpected pixel write at x %0d y %0d", out_data_i.pix_x,
                 out_data_i.pix_y);
          fails++;
        end else begin
          want = writes_due.pop_front();
          fails += field_bad("pix_x", want.pix_x, out_data_i.pix_x);
          fails += field_bad("pix_y", want.pix_y, out_data_i.pix_y);
          fails += field_bad("pix_value", 10'(want.pix_value), 10'(out_data_i.pix_value));
          fails += field_bad("pix_layer", 10'(want.pix_layer), 10'(out_data_i.pix_layer));
          fails += field_bad("last", 10'(want.last), 10'(out_data_i.last));
        end
      end
      if (in_valid_i && !in_stall_i) predict_writes(in_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgScreenWidth:  scr_w <= cfg_data_i;
          CfgScreenHeight: scr_h <= cfg_data_i;
          default: ;
        endcase
      end
      writes_due_o <= writes_due.size();
      fail_cnt_o   <= fails;
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: sprite stimulus, screen size phases, receiver stalls and the verdict
// depends on sbb_pkg, sprite_blit_blend_top and sbb_write_checker
module tb_top;
  import sbb_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [0:0]      cfg_idx_i = CfgScreenWidth;
  logic [DimW-1:0] cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  sbb_in_t         in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  sbb_out_t        out_data_o;
  int              fail_cnt;
  int              writes_due;
  int unsigned     cur_w = 400;
  int unsigned     cur_h = 240;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sprite_blit_blend_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  sbb_write_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .writes_due_o (writes_due),
    .fail_cnt_o   (fail_cnt)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_coord(input int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return 16'($urandom_range(65528, 65535));
    if (r < 4) return 16'(lim + 8 - $urandom_range(0, 15));
    return 16'($urandom_range(0, lim));
  endfunction

  function automatic logic [63:0] pick_plane();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic sbb_in_t make_sprite(input logic [15:0] px, input logic [15:0] py,
                                          input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [3:0] mode, input logic fx,
                                          input logic fy, input logic bpp,
                                          input logic layer);
    sbb_in_t spr;
    spr.pos_x      = px;
    spr.pos_y      = py;
    spr.plane_low  = lo;
    spr.plane_high = hi;
    spr.color_mode = mode;
    spr.flip_x     = fx;
    spr.flip_y     = fy;
    spr.two_bpp    = bpp;
    spr.layer_sel  = layer;
    return spr;
  endfunction

  function automatic sbb_in_t rand_sprite(input int unsigned w, input int unsigned h);
    int unsigned wl;
    int unsigned hl;
    wl = (w > 1024) ? 1024 : w;
    hl = (h > 1024) ? 1024 : h;
    return make_sprite(pick_coord(wl), pick_coord(hl), pick_plane(), pick_plane(),
                       4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom),
                       1'($urandom), 1'($urandom));
  endfunction

  task automatic send_sprite(input sbb_in_t spr, input int unsigned gap);
    in_valid_i <= 1'b1;
    in_data_i  <= spr;
    do @(posedge clk_i); while (in_stall_o);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (writes_due != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_screen(input int unsigned w, input int unsigned h);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgScreenWidth;
    cfg_data_i <= w[DimW-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CfgScreenHeight;
    cfg_data_i <= h[DimW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // receiver stalls: short and long runs, with occasional calm stretches
  initial begin : rx_stall
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 4))
        @(posedge clk_i);
    end
  end

  initial begin : watchdog
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned n_items;
    int unsigned gap;
    int unsigned burst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sprite(make_sprite(16'd0, 16'd0, '1, '1, 4'd1, 1'b0, 1'b0, 1'b1, 1'b0), 0);
    send_sprite(make_sprite(16'd8, 16'd8, '0, '0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b1), 0);
    send_sprite(make_sprite(16'd16, 16'd8, '0, '0, 4'd2, 1'b1, 1'b0, 1'b1, 1'b0), 2);
    for (int m = 0; m < 16; m++) begin
      send_sprite(make_sprite(16'(16*m), 16'(8*m), 64'h0123_4567_89AB_CDEF,
                              64'hF0E1_D2C3_B4A5_9687, 4'(m), m[0], m[1], m != 6, m[3]),
                  pick_gap());
    end
    // wrapped positions
    send_sprite(make_sprite(16'd65532, 16'd65533, '1, '0, 4'd1, 1'b0, 1'b1, 1'b1, 1'b0), 0);
    send_sprite(make_sprite(16'hFFFF, 16'hFFFF, '1, '1, 4'd3, 1'b1, 1'b1, 1'b1, 1'b1), 1);
    // partly and fully clipped at the right and bottom edges
    send_sprite(make_sprite(16'd396, 16'd236, '1, 64'h8142_2418_1824_4281, 4'd9,
                            1'b0, 1'b0, 1'b1, 1'b1), 0);
    send_sprite(make_sprite(16'd400, 16'd100, '1, '1, 4'd1, 1'b0, 1'b0, 1'b1, 1'b0), 0);
    send_sprite(make_sprite(16'd0, 16'd240, '1, '1, 4'd1, 1'b0, 1'b0, 1'b1, 1'b0), 3);
    // second plane ignored in one bit per pixel mode
    send_sprite(make_sprite(16'd100, 16'd50, 64'h55AA_33CC_0FF0_F00F, '1, 4'd5,
                            1'b1, 1'b0, 1'b0, 1'b1), 0);

    burst = 0;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: n_items = 50;
        1: begin
          set_screen(8, 8);
          n_items = 45;
        end
        2: begin
          set_screen(1024, 1024);
          n_items = 55;
        end
        3: begin
          set_screen(2047, 2047);
          n_items = 55;
        end
        4: begin
          set_screen(0, 1024);
          n_items = 15;
        end
        5: begin
          set_screen(1024, 0);
          n_items = 15;
        end
        6: begin
          set_screen(5, 3);
          n_items = 40;
        end
        7: begin
          set_screen(1023, 600);
          n_items = 55;
        end
        default: begin
          set_screen($urandom_range(8, 1024), $urandom_range(8, 1024));
          n_items = 50;
        end
      endcase
      for (int i = 0; i < n_items; i++) begin
        if (burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(10, 30);
        if (burst > 0) begin
          gap = 0;
          burst--;
        end else begin
          gap = pick_gap();
        end
        send_sprite(rand_sprite(cur_w, cur_h), gap);
      end
    end

    drain();
    if (fail_cnt == 0 && writes_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
